### src/ntt_pkg.sv
// Shared types and constants for the radix-2 NTT unit modulo 998244353.
// Used by the top level and the modular multiplier; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ntt_pkg;
   localparam logic [29:0] PRIME = 30'd998244353;
   localparam int unsigned RES_W = 30;

   typedef logic [RES_W-1:0] residue_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PERM_RD,
      ST_PERM_WAIT,
      ST_PERM_WR,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_WR,
      ST_REV_RD,
      ST_REV_WAIT,
      ST_REV_WR,
      ST_SCL_RD,
      ST_SCL_MUL,
      ST_SCL_WR,
      ST_READY
   } state_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Stage root 3^((P-1)/2^s) for s = 1..20.
   function automatic residue_type stage_root(input logic [4:0] s);
      residue_type r;
      r = 30'd1;
      case (s)
         5'd1:  r = 30'd998244352;
         5'd2:  r = 30'd911660635;
         5'd3:  r = 30'd372528824;
         5'd4:  r = 30'd929031873;
         5'd5:  r = 30'd452798380;
         5'd6:  r = 30'd922799308;
         5'd7:  r = 30'd781712469;
         5'd8:  r = 30'd476477967;
         5'd9:  r = 30'd166035806;
         5'd10: r = 30'd258648936;
         5'd11: r = 30'd584193783;
         5'd12: r = 30'd63912897;
         5'd13: r = 30'd350007156;
         5'd14: r = 30'd666702199;
         5'd15: r = 30'd968855178;
         5'd16: r = 30'd629671588;
         5'd17: r = 30'd24514907;
         5'd18: r = 30'd996173970;
         5'd19: r = 30'd363395222;
         5'd20: r = 30'd565042129;
         default: r = 30'd1;
      endcase
      return r;
   endfunction

   // len^-1 mod P for len = 2^lg, lg = 1..20.
   function automatic residue_type inv_len(input logic [4:0] lg);
      residue_type r;
      r = 30'd1;
      case (lg)
         5'd1:  r = 30'd499122177;
         5'd2:  r = 30'd748683265;
         5'd3:  r = 30'd873463809;
         5'd4:  r = 30'd935854081;
         5'd5:  r = 30'd967049217;
         5'd6:  r = 30'd982646785;
         5'd7:  r = 30'd990445569;
         5'd8:  r = 30'd994344961;
         5'd9:  r = 30'd996294657;
         5'd10: r = 30'd997269505;
         5'd11: r = 30'd997756929;
         5'd12: r = 30'd998000641;
         5'd13: r = 30'd998122497;
         5'd14: r = 30'd998183425;
         5'd15: r = 30'd998213889;
         5'd16: r = 30'd998229121;
         5'd17: r = 30'd998236737;
         5'd18: r = 30'd998240545;
         5'd19: r = 30'd998242449;
         5'd20: r = 30'd998243401;
         default: r = 30'd1;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

### src/ntt_radix2_mod_prime_unit.sv
// Top level of the radix-2 number theoretic transform modulo 998244353.
// Depends on ntt_pkg, ntt_ram (coefficient store) and ntt_mulmod.
`timescale 1ns / 1ps
`default_nettype none
// The unit collects 2^log_length residues (log_length clamped to 1..AW), one
// load transaction per cycle while the output register is free, into a single
// coefficient RAM. The load that completes a set starts the transform: a
// bit-reversal pass swapping each entry with its mirror, then a butterfly stage
// per bit of the length, len/2 butterflies each, each stepping through read,
// multiply and write states as the one RAM port pair carries two reads and two
// writes and the modular multiplier sits in the loop. Inverse transforms add a
// reversal pass over swapped pairs and a scaling pass over every entry. While
// the transform runs req_tready is low. Afterwards each read transaction
// returns one result through a registered output stage; since read data
// arrives in the cycle after the transaction and the request side waits for
// it, each read waits for the previous one's data. A load issued while
// results are pending drops them and starts a new set; a read with nothing
// pending is consumed without a result. Writing csr aborts any set in progress.
module ntt_radix2_mod_prime_unit #(
   parameter int MAX_POINTS = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire [3:0]   csr_wr_data,   // log_length
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [31:0]  req_tdata,     // [29:0] value
   input  wire [1:0]   req_tuser,     // [0] op, [1] inverse
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,     // [29:0] result_value, [39:30] result_index
   output logic        rsp_tlast
);
   import ntt_pkg::*;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = AW + 1;
   localparam int MAXLOG = AW;

   state_type state_ff, state_in;
   logic [3:0] log_ff;
   logic [4:0] lg;
   logic [CW-1:0] n;
   logic [CW-1:0] cnt_ff, cnt_in;       // load count / read count / loop index
   logic [CW-1:0] grp_ff, grp_in;       // butterfly group base
   logic [4:0] stage_ff, stage_in;
   logic inv_ff, inv_in;
   residue_type tw_ff, tw_in, root_ff, root_in;
   residue_type u_ff, u_in;
   residue_type t_ff, t_in;
   logic ready_ff, ready_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   residue_type wr_data, rd_data;
   residue_type ma, mb, mp;
   logic [2:0] mcnt_ff, mcnt_in;

   logic req_fire, out_free;
   logic rsp_valid_ff, rsp_valid_in;
   residue_type rsp_val_ff;
   logic [9:0] rsp_idx_ff;
   logic rsp_last_ff;
   logic [AW-1:0] rd_idx_ff;
   logic rd_pend_ff, rd_last_ff;

   // Effective length.
   always_comb begin
      lg = {1'b0, log_ff};
      if (lg == 5'd0) lg = 5'd1;
      if (lg > 5'(MAXLOG)) lg = 5'(MAXLOG);
      n = CW'(1) << lg;
   end

   function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] x, input logic [4:0] l);
      logic [AW-1:0] r;
      r = '0;
      for (int k = 0; k < AW; k++) begin
         if (k < int'(l) && x[k]) r[int'(l) - 1 - k] = 1'b1;
      end
      return r;
   endfunction

   ntt_ram #(.WIDTH(RES_W), .DEPTH(MAX_POINTS)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );
   ntt_mulmod u_mul (.clock(clock), .a(ma), .b(mb), .p(mp));

   logic [29:0] in_val;
   assign in_val = req_tdata[29:0] >= PRIME ? req_tdata[29:0] - PRIME : req_tdata[29:0];

   logic [CW-1:0] half, k_lo, k_hi, rev_j;
   logic [AW-1:0] br;
   residue_type bsum, bdif, t;
   logic [30:0] s31;
   assign half = CW'(1) << (stage_ff - 5'd1);
   assign k_lo = grp_ff + cnt_ff;
   assign k_hi = k_lo + half;
   assign br = bitrev(cnt_ff[AW-1:0], lg);
   assign rev_j = n - cnt_ff;
   assign t = t_ff;
   assign s31 = {1'b0, u_ff} + {1'b0, t};
   assign bsum = s31 >= {1'b0, PRIME} ? 30'(s31 - {1'b0, PRIME}) : s31[29:0];
   assign bdif = u_ff >= t ? u_ff - t : 30'(({1'b0, u_ff} + {1'b0, PRIME}) - {1'b0, t});

   // A read waiting for its RAM data also holds off the next transaction, so the
   // single output register is never overwritten.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_LOAD || state_ff == ST_READY) && out_free &&
                       !rd_pend_ff;
   assign req_fire = req_tvalid && req_tready;

   // Next state and datapath sequencing.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; grp_in = grp_ff; stage_in = stage_ff;
      inv_in = inv_ff; tw_in = tw_ff; root_in = root_ff; u_in = u_ff;
      t_in = t_ff;
      ready_in = ready_ff; mcnt_in = mcnt_ff;
      case (state_ff)
         ST_LOAD, ST_READY: begin
            if (req_fire && req_tuser[0] == OP_LOAD) begin
               if (state_ff == ST_LOAD && cnt_ff + 1'b1 >= n) begin
                  cnt_in = '0; inv_in = req_tuser[1]; ready_in = 1'b0;
                  state_in = ST_PERM_RD;
               end else begin
                  cnt_in = state_ff == ST_READY ? CW'(1) : cnt_ff + 1'b1;
                  ready_in = 1'b0;
                  state_in = ST_LOAD;
               end
            end else if (req_fire && ready_ff) begin
               if (cnt_ff + 1'b1 >= n) begin
                  cnt_in = '0; ready_in = 1'b0; state_in = ST_LOAD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_PERM_RD: begin
            if ({1'b0, br} > cnt_ff) state_in = ST_PERM_WAIT;
            else if (cnt_ff + 1'b1 >= n) begin
               cnt_in = '0; grp_in = '0; stage_in = 5'd1; tw_in = 30'd1;
               root_in = stage_root(5'd1); mcnt_in = '0; state_in = ST_BF_RD;
            end else cnt_in = cnt_ff + 1'b1;
         end
         ST_PERM_WAIT: begin
            u_in = rd_data; state_in = ST_PERM_WR;   // u = store[i]
         end
         ST_PERM_WR: begin
            // Write store[i] <= store[r] now read; then store[r] <= u next.
            if (mcnt_ff == 3'd0) mcnt_in = 3'd1;
            else begin
               mcnt_in = '0;
               if (cnt_ff + 1'b1 >= n) begin
                  cnt_in = '0; grp_in = '0; stage_in = 5'd1; tw_in = 30'd1;
                  root_in = stage_root(5'd1); state_in = ST_BF_RD;
               end else begin
                  cnt_in = cnt_ff + 1'b1; state_in = ST_PERM_RD;
               end
            end
         end
         ST_BF_RD: begin
            // First read hi, then read lo while hi data goes to the multiplier.
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd1) begin
               mcnt_in = '0; state_in = ST_BF_MUL;
            end
         end
         ST_BF_MUL: begin
            if (mcnt_ff == 3'd0) u_in = rd_data;
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd1) begin
               // The twiddled upper operand leaves the multiplier this cycle.
               t_in = mp;
               mcnt_in = '0; state_in = ST_BF_WR;
            end
         end
         ST_BF_WR: begin
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd0) begin
               tw_in = mp;   // twiddle product arrives this cycle
            end else begin
               mcnt_in = '0;
               state_in = ST_BF_RD;
               if (cnt_ff + 1'b1 >= half) begin
                  cnt_in = '0; tw_in = 30'd1;
                  if (grp_ff + (half << 1) >= n) begin
                     grp_in = '0;
                     if (stage_ff >= lg) begin
                        cnt_in = CW'(1);
                        state_in = inv_ff ? ST_REV_RD : ST_READY;
                        if (!inv_ff) begin cnt_in = '0; ready_in = 1'b1; end
                     end else begin
                        stage_in = stage_ff + 5'd1;
                        root_in = stage_root(stage_ff + 5'd1);
                     end
                  end else grp_in = grp_ff + (half << 1);
               end else cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_REV_RD: begin
            if (cnt_ff >= (n >> 1)) begin
               cnt_in = '0; state_in = ST_SCL_RD;
            end else state_in = ST_REV_WAIT;
         end
         ST_REV_WAIT: begin
            u_in = rd_data; state_in = ST_REV_WR;
         end
         ST_REV_WR: begin
            if (mcnt_ff == 3'd0) mcnt_in = 3'd1;
            else begin
               mcnt_in = '0; cnt_in = cnt_ff + 1'b1; state_in = ST_REV_RD;
            end
         end
         ST_SCL_RD: state_in = ST_SCL_MUL;
         ST_SCL_MUL: begin
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd2) begin
               mcnt_in = '0; state_in = ST_SCL_WR;
            end
         end
         ST_SCL_WR: begin
            if (cnt_ff + 1'b1 >= n) begin
               cnt_in = '0; ready_in = 1'b1; state_in = ST_READY;
            end else begin
               cnt_in = cnt_ff + 1'b1; state_in = ST_SCL_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
      if (csr_wr_en) begin
         state_in = ST_LOAD; cnt_in = '0; ready_in = 1'b0; mcnt_in = '0;
      end
   end

   // Memory and multiplier port control.
   always_comb begin
      wr_en = 1'b0; wr_addr = cnt_ff[AW-1:0]; wr_data = in_val;
      rd_addr = cnt_ff[AW-1:0]; ma = tw_ff; mb = rd_data;
      case (state_ff)
         ST_LOAD, ST_READY: begin
            wr_en = req_fire && req_tuser[0] == OP_LOAD;
            wr_addr = state_ff == ST_READY ? '0 : cnt_ff[AW-1:0];
            if (!ready_ff) wr_addr = cnt_ff[AW-1:0];
            if (state_ff == ST_READY && ready_ff) wr_addr = '0;
            rd_addr = cnt_ff[AW-1:0];
         end
         ST_PERM_RD: rd_addr = cnt_ff[AW-1:0];
         ST_PERM_WAIT: rd_addr = br;
         ST_PERM_WR: begin
            wr_en = 1'b1;
            wr_addr = mcnt_ff == 3'd0 ? cnt_ff[AW-1:0] : br;
            wr_data = mcnt_ff == 3'd0 ? rd_data : u_ff;
            rd_addr = br;
         end
         ST_BF_RD: begin
            rd_addr = mcnt_ff == 3'd0 ? k_hi[AW-1:0] : k_lo[AW-1:0];
         end
         ST_BF_MUL: begin
            rd_addr = k_lo[AW-1:0];
            ma = tw_ff;
            mb = mcnt_ff == 3'd0 ? root_ff : rd_data;
         end
         ST_BF_WR: begin
            wr_en = 1'b1;
            wr_addr = mcnt_ff == 3'd0 ? k_lo[AW-1:0] : k_hi[AW-1:0];
            wr_data = mcnt_ff == 3'd0 ? bsum : bdif;
         end
         ST_REV_RD: rd_addr = cnt_ff[AW-1:0];
         ST_REV_WAIT: rd_addr = rev_j[AW-1:0];
         ST_REV_WR: begin
            wr_en = 1'b1;
            wr_addr = mcnt_ff == 3'd0 ? cnt_ff[AW-1:0] : rev_j[AW-1:0];
            wr_data = mcnt_ff == 3'd0 ? rd_data : u_ff;
            rd_addr = rev_j[AW-1:0];
         end
         ST_SCL_RD: rd_addr = cnt_ff[AW-1:0];
         ST_SCL_MUL: begin
            ma = inv_len(lg); mb = rd_data; rd_addr = cnt_ff[AW-1:0];
         end
         ST_SCL_WR: begin
            wr_en = 1'b1; wr_addr = cnt_ff[AW-1:0]; wr_data = mp;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; log_ff <= 4'd10; cnt_ff <= '0; ready_ff <= 1'b0;
         mcnt_ff <= '0; rd_pend_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ready_ff <= ready_in;
         mcnt_ff <= mcnt_in;
         if (csr_wr_en) log_ff <= csr_wr_data;
         rd_pend_ff <= req_fire && req_tuser[0] == OP_READ && ready_ff && !csr_wr_en;
         rsp_valid_ff <= rsp_valid_in;
      end
      grp_ff <= grp_in; stage_ff <= stage_in; inv_ff <= inv_in;
      tw_ff <= tw_in; root_ff <= root_in; u_ff <= u_in; t_ff <= t_in;
      rd_idx_ff <= cnt_ff[AW-1:0];
      rd_last_ff <= cnt_ff + 1'b1 >= n;
      if (rd_pend_ff) begin
         rsp_val_ff <= rd_data;
         rsp_idx_ff <= 10'(rd_idx_ff);
         rsp_last_ff <= rd_last_ff;
      end
   end

   // Read data lands in the cycle after the read transaction. The transaction
   // was only taken with the output register free or draining, and nothing
   // else is accepted while the data is pending, so the register is free here.
   assign rsp_valid_in = rd_pend_ff ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_idx_ff, rsp_val_ff};
   assign rsp_tlast = rsp_last_ff;
endmodule
`default_nettype wire

### src/ntt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module ntt_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### src/ntt_mulmod.sv
// Pipelined multiplier a*b mod 998244353: product, then quotient, registered.
// Uses ntt_pkg for the prime; Barrett reduction with a 32-bit mu.
`timescale 1ns / 1ps
`default_nettype none
module ntt_mulmod (
   input  wire                  clock,
   input  ntt_pkg::residue_type a,
   input  ntt_pkg::residue_type b,
   output ntt_pkg::residue_type p
);
   import ntt_pkg::*;
   // mu = floor(2^60 / P)
   localparam logic [31:0] MU = 32'd1154949187;

   logic [59:0] prod_ff;
   logic [59:0] prod2_ff;
   logic [31:0] quot_ff;
   logic [61:0] qmu;
   logic [59:0] rem_full;
   logic [31:0] rem;

   assign qmu = 62'(prod_ff[59:29]) * 62'(MU);

   always_ff @(posedge clock) begin
      prod_ff  <= 60'(a) * 60'(b);
      prod2_ff <= prod_ff;
      quot_ff  <= 32'(qmu[61:31]);
   end

   // Quotient estimate is at most two below the true one.
   assign rem_full = prod2_ff - 60'(quot_ff) * 60'(PRIME);
   always_comb begin
      rem = rem_full[31:0];
      if (rem >= {2'b0, PRIME}) rem = rem - {2'b0, PRIME};
      if (rem >= {2'b0, PRIME}) rem = rem - {2'b0, PRIME};
   end
   assign p = rem[29:0];
endmodule
`default_nettype wire

### src/ntt_checker.sv
// Port-level checker for ntt_radix2_mod_prime_unit, bound to the top level.
// Depends on ntt_pkg for the prime.
`timescale 1ns / 1ps
`default_nettype none
module ntt_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata,
   input wire        rsp_tlast
);
   import ntt_pkg::*;
   a_val_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:0] < PRIME) else $error("result not reduced");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid && !$stable(rsp_tdata)
      |-> rsp_tdata[39:30] != $past(rsp_tdata[39:30]))
      else $error("index did not advance");
   a_no_fire_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready) else $error("accepted while stalled");
endmodule
bind ntt_radix2_mod_prime_unit ntt_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for ntt_radix2_mod_prime_unit.
// Depends on ntt_pkg and the unit's RTL. It predicts every result with its own transform
// model and compares each result transaction field by field.
`timescale 1ns / 1ps
module testbench;
   import ntt_pkg::*;

   localparam longint unsigned MODULUS = 64'd998244353;
   localparam int MAX_PTS = 1024;
   localparam int MAX_LOG = 10;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [29:0] coeff;
      logic [9:0]  position;
      logic        final_flag;
   } coeff_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = 4'd0;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic [1:0]  req_tuser = 2'd0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire [39:0]  rsp_tdata;
   wire         rsp_tlast;

   // Shadow of the unit's state, kept at the transaction level.
   logic [29:0]   shadow_store [MAX_PTS];
   logic [3:0]    shadow_log = 4'd10;
   int unsigned   shadow_loaded = 0;
   int unsigned   shadow_read = 0;
   bit            shadow_ready = 1'b0;
   coeff_result_type pending_coeffs [$];

   int      error_count = 0;
   int      item_count = 0;
   bit      no_idle = 1'b0;
   longint  cycle_count = 0;

   ntt_radix2_mod_prime_unit #(.MAX_POINTS(MAX_PTS)) dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The run is bounded by a generous cycle limit; the transform itself holds req_tready low.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ntt_radix2_mod_prime_unit regression: fail");
         $finish;
      end
   end

   function automatic logic [29:0] mod_mul(logic [29:0] a, logic [29:0] b);
      longint unsigned prod;
      prod = longint'(a) * longint'(b);
      return 30'(prod % MODULUS);
   endfunction

   function automatic logic [29:0] mod_pow(logic [29:0] base, longint unsigned e);
      logic [29:0] acc;
      acc = 30'd1;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, base);
         base = mod_mul(base, base);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic int active_log();
      if (shadow_log < 1) return 1;
      if (shadow_log > MAX_LOG) return MAX_LOG;
      return shadow_log;
   endfunction

   // Bit reversal, decimation-in-time butterflies, and for the inverse a reversal and scaling.
   function automatic void run_transform(int lg, bit inv);
      int n;
      int rev;
      int half;
      logic [29:0] swap, root, twiddle, u, t, scale;
      longint unsigned sum;
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
         rev = 0;
         for (int k = 0; k < lg; k++) if (i[k]) rev |= 1 << (lg - 1 - k);
         if (rev > i) begin
            swap = shadow_store[i];
            shadow_store[i] = shadow_store[rev];
            shadow_store[rev] = swap;
         end
      end
      for (int s = 1; s <= lg; s++) begin
         half = 1 << (s - 1);
         root = mod_pow(30'd3, (MODULUS - 1) >> s);
         for (int j = 0; j < n; j += 2 * half) begin
            twiddle = 30'd1;
            for (int k = j; k < j + half; k++) begin
               u = shadow_store[k];
               t = mod_mul(twiddle, shadow_store[k + half]);
               sum = longint'(u) + longint'(t);
               if (sum >= MODULUS) sum -= MODULUS;
               shadow_store[k] = 30'(sum);
               shadow_store[k + half] = (u >= t) ? u - t : 30'(longint'(u) + MODULUS - t);
               twiddle = mod_mul(twiddle, root);
            end
         end
      end
      if (inv) begin
         for (int i = 1; i < n / 2; i++) begin
            swap = shadow_store[i];
            shadow_store[i] = shadow_store[n - i];
            shadow_store[n - i] = swap;
         end
         scale = mod_pow(30'(n), MODULUS - 2);
         for (int i = 0; i < n; i++) shadow_store[i] = mod_mul(shadow_store[i], scale);
      end
   endfunction

   // Advances the shadow state by one accepted request and queues any result it causes.
   function automatic void predict_request(bit op, logic [29:0] v, bit inv);
      int lg;
      int n;
      coeff_result_type r;
      lg = active_log();
      n = 1 << lg;
      if (op == OP_LOAD) begin
         if (shadow_ready) begin
            shadow_ready = 1'b0;
            shadow_read = 0;
            shadow_loaded = 0;
         end
         if (longint'(v) >= MODULUS) v = 30'(longint'(v) - MODULUS);
         if (shadow_loaded >= n) shadow_loaded = 0;
         shadow_store[shadow_loaded] = v;
         shadow_loaded++;
         if (shadow_loaded >= n) begin
            run_transform(lg, inv);
            shadow_loaded = 0;
            shadow_read = 0;
            shadow_ready = 1'b1;
         end
      end else if (shadow_ready) begin
         if (shadow_read >= n) shadow_read = 0;
         r.coeff = shadow_store[shadow_read];
         r.position = shadow_read[9:0];
         r.final_flag = (shadow_read == n - 1);
         pending_coeffs.push_back(r);
         shadow_read++;
         if (shadow_read >= n) begin
            shadow_read = 0;
            shadow_ready = 1'b0;
         end
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Sends one request transaction; called and returning at a falling edge.
   task automatic send_request(bit op, logic [29:0] v, bit inv);
      if (!no_idle) while ($urandom_range(99) < 37) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {2'b00, v};
      req_tuser = {inv, op};
      do @(posedge clock); while (!req_tready);
      if (op == OP_LOAD || shadow_ready) item_count++;
      predict_request(op, v, inv);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Waits for all queued results, then long enough for the longest inverse transform
   // to finish (bit reversal, butterflies, reversal and scaling passes).
   task automatic settle();
      int n;
      int lg;
      lg = active_log();
      n = 1 << lg;
      while (pending_coeffs.size() != 0) @(negedge clock);
      repeat (n * (12 + 3 * lg) + 100) @(negedge clock);
   endtask

   task automatic write_length(logic [3:0] lg);
      settle();
      csr_wr_en = 1'b1;
      csr_wr_data = lg;
      @(negedge clock);
      csr_wr_en = 1'b0;
      shadow_log = lg;
      shadow_loaded = 0;
      shadow_read = 0;
      shadow_ready = 1'b0;
   endtask

   // Loads a set of random residues, sometimes at or above the prime.
   task automatic load_set(bit inv);
      int n;
      logic [29:0] v;
      n = 1 << active_log();
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: v = 30'h3FFFFFFF - 30'($urandom_range(20));
            1: v = PRIME + 30'($urandom_range(20));
            2: v = PRIME - 30'd1;
            default: v = 30'($urandom);
         endcase
         send_request(OP_LOAD, v, inv);
      end
   endtask

   task automatic read_results(int count);
      for (int i = 0; i < count; i++) send_request(OP_READ, 30'($urandom), $urandom_range(1));
   endtask

   // Result side: the ready pattern and the field by field comparison.
   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      coeff_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_coeffs.size() == 0) begin
            report_mismatch("unexpected result index", rsp_tdata[39:30], -1);
         end else begin
            want = pending_coeffs.pop_front();
            if (rsp_tdata[29:0] !== want.coeff)
               report_mismatch("result_value", rsp_tdata[29:0], want.coeff);
            if (rsp_tdata[39:30] !== want.position)
               report_mismatch("result_index", rsp_tdata[39:30], want.position);
            if (rsp_tlast !== want.final_flag)
               report_mismatch("last", rsp_tlast, want.final_flag);
         end
      end
   end

   // Extremes of the value field, both directions, idle reads, aborts and out of range lengths.
   task automatic test_directed();
      write_length(4'd1);
      send_request(OP_READ, 30'd0, 1'b0);
      send_request(OP_LOAD, 30'd0, 1'b0);
      send_request(OP_LOAD, PRIME - 30'd1, 1'b0);
      read_results(2);
      send_request(OP_LOAD, 30'h3FFFFFFF, 1'b1);
      send_request(OP_LOAD, PRIME, 1'b1);
      read_results(3);
      write_length(4'd0);
      send_request(OP_LOAD, 30'd7, 1'b0);
      send_request(OP_LOAD, 30'd9, 1'b1);
      read_results(1);
      // A load while results are still pending drops them and opens a new set.
      send_request(OP_LOAD, 30'd5, 1'b0);
      send_request(OP_LOAD, 30'd11, 1'b0);
      read_results(2);
      write_length(4'd2);
      send_request(OP_LOAD, 30'd1, 1'b0);
      // The register write aborts the partial set.
      write_length(4'd2);
      load_set(1'b1);
      read_results(4);
   endtask

   // One full-length set through the clamped register value, driven with no idle cycles.
   // Only the first results are read; the next register write drops the rest.
   task automatic test_full_length();
      write_length(4'd15);
      no_idle = 1'b1;
      load_set(1'b1);
      read_results(128);
      no_idle = 1'b0;
   endtask

   task automatic test_random_sets();
      int n;
      int reads;
      int phase;
      logic [3:0] lg;
      phase = 0;
      while (item_count < 1250) begin
         case ($urandom_range(9))
            0: lg = 4'd0;
            1: lg = 4'($urandom_range(6, 7));
            default: lg = 4'($urandom_range(1, 4));
         endcase
         write_length(lg);
         no_idle = (phase == 3);
         n = 1 << active_log();
         repeat ($urandom_range(3, 6)) begin
            if (item_count >= 1250) break;
            load_set($urandom_range(1));
            reads = ($urandom_range(9) == 0) ? $urandom_range(n) : n;
            read_results(reads);
            if ($urandom_range(4) == 0) read_results($urandom_range(1, 3));
         end
         no_idle = 1'b0;
         phase++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_length();
      test_random_sets();
      settle();
      if (error_count == 0) begin
         $display("ntt_radix2_mod_prime_unit regression: pass");
      end else begin
         $display("ntt_radix2_mod_prime_unit regression: fail");
      end
      $finish;
   end
endmodule

### filelist.f
src/ntt_pkg.sv
src/ntt_ram.sv
src/ntt_mulmod.sv
src/ntt_radix2_mod_prime_unit.sv
src/ntt_checker.sv
verif/testbench.sv
